@@ sv/cau_pkg.sv @@
`default_nettype none
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAG_W      = 2 * DATA_WIDTH + 2;
    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] REQ_ADD = 3'd0;
    localparam logic [2:0] REQ_SUB = 3'd1;
    localparam logic [2:0] REQ_MUL = 3'd2;
    localparam logic [2:0] REQ_DIV = 3'd3;
    localparam logic [2:0] REQ_NEG = 3'd4;
    localparam logic [2:0] REQ_CMP = 3'd5;

    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SUB  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_NEG  = 3'd4;
    localparam logic [2:0] KIND_CMP  = 3'd5;
    localparam logic [2:0] KIND_NONE = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (DATA_WIDTH - 1);
    localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);
    localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic [2:0] req_type;
        data_t      a_re;
        data_t      a_im;
        data_t      b_re;
        data_t      b_im;
    } req_t;

    typedef struct packed {
        data_t      res_re;
        data_t      res_im;
        logic       is_equal;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [2:0] kind;
        data_t      a_re;
        data_t      a_im;
        data_t      b_re;
        data_t      b_im;
    } cmd_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  sat;
    } sat_t;

    function automatic logic [MAG_W-1:0] magnitude(input logic [MAG_W-1:0] x);
        return x[MAG_W-1] ? (MAG_W'(0) - x) : x;
    endfunction

    // clamp a sign and magnitude pair to the signed data range
    function automatic sat_t saturate(input logic neg, input logic [MAG_W-1:0] mag,
                                      input logic big);
        sat_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (big || mag > NEG_LIM) begin
                r.val = DATA_MIN;
                r.sat = 1'b1;
            end else begin
                r.val = DATA_WIDTH'(MAG_W'(0) - mag);
            end
        end else begin
            if (big || mag > POS_LIM) begin
                r.val = DATA_MAX;
                r.sat = 1'b1;
            end else begin
                r.val = mag[DATA_WIDTH-1:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/complex_arithmetic_unit.sv @@
// division uses a restoring divider that resolves one quotient bit per pipeline stage
// throughput: one item per cycle unless a low m_ready stalls the output; every request type
//   takes the same path so order is kept
// input register and a 4-entry queue separate the front end from the arithmetic pipeline
// reset: aresetn synchronous active low, clears all valid flags and queue pointers
`default_nettype none
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cau_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cau_pkg::rsp_t m_data
);
    import cau_pkg::*;

    logic f_valid, f_ready;
    cmd_t f_cmd;
    logic q_valid, q_ready;
    cmd_t q_cmd;

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    cau_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

@@ sv/cau_front.sv @@
`default_nettype none
module cau_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cau_pkg::req_t s_data,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output cau_pkg::cmd_t cmd
);
    import cau_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;

    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        cmd_next.a_re = s_data.a_re;
        cmd_next.a_im = s_data.a_im;
        cmd_next.b_re = s_data.b_re;
        cmd_next.b_im = s_data.b_im;
        case (s_data.req_type)
            REQ_ADD: cmd_next.kind = KIND_ADD;
            REQ_SUB: cmd_next.kind = KIND_SUB;
            REQ_MUL: cmd_next.kind = KIND_MUL;
            REQ_DIV: cmd_next.kind = KIND_DIV;
            REQ_NEG: cmd_next.kind = KIND_NEG;
            REQ_CMP: cmd_next.kind = KIND_CMP;
            default: cmd_next.kind = KIND_NONE;
        endcase
    end

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/cau_fifo.sv @@
`default_nettype none
module cau_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  cau_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output cau_pkg::cmd_t out_cmd
);
    import cau_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(FIFO_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next  = push ? PTR_W'(wptr_reg + 1'b1) : wptr_reg;
        rptr_next  = pop ? PTR_W'(rptr_reg + 1'b1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

@@ sv/cau_back.sv @@
`default_nettype none
module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cau_pkg::cmd_t cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output cau_pkg::rsp_t m_data
);
    import cau_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int PW   = 2 * W;
    localparam int NDIV = W + 1;
    localparam int NW   = PW + FRAC_BITS;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic [PW-1:0]        sq_r;
        logic [PW-1:0]        sq_i;
        rsp_t                 res;
    } s1_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [PW:0] sum_re;
        logic [PW:0] sum_im;
        logic [PW-1:0] den;
        rsp_t        res;
    } s2_t;

    typedef struct packed {
        logic          is_div;
        logic          ovf_re;
        logic          ovf_im;
        logic          neg_re;
        logic          neg_im;
        logic [PW-1:0] den;
        logic [PW-1:0] num_re;
        logic [PW-1:0] num_im;
        logic [PW-1:0] rem_re;
        logic [PW-1:0] rem_im;
        logic [W:0]    q_re;
        logic [W:0]    q_im;
        rsp_t          res;
    } dstage_t;

    logic    adv;
    logic    v1_reg, v2_reg, out_valid_reg;
    logic    dv_reg [0:NDIV];
    s1_t     s1_reg, s1_next;
    s2_t     s2_reg, s2_next;
    dstage_t dst_reg  [0:NDIV];
    dstage_t dst_next [0:NDIV];
    logic    nb_re [0:NDIV-1];
    logic    nb_im [0:NDIV-1];
    rsp_t    out_reg, out_next;

    // whole back end moves together whenever the output slot frees up
    assign adv       = !out_valid_reg || m_ready;
    assign cmd_ready = adv;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    function automatic sat_t sat_signed(input logic [MAG_W-1:0] x);
        return saturate(x[MAG_W-1], magnitude(x), 1'b0);
    endfunction

    // stage 1: products, squares and the add, subtract, negate and compare results
    always_comb begin
        logic [MAG_W-1:0] x_re, x_im;
        sat_t             r_re, r_im;
        logic signed [PW-1:0] sr, si;
        s1_next.kind = cmd.kind;
        s1_next.p_rr = cmd.a_re * cmd.b_re;
        s1_next.p_ii = cmd.a_im * cmd.b_im;
        s1_next.p_ri = cmd.a_re * cmd.b_im;
        s1_next.p_ir = cmd.a_im * cmd.b_re;
        sr = cmd.b_re * cmd.b_re;
        si = cmd.b_im * cmd.b_im;
        s1_next.sq_r = sr;
        s1_next.sq_i = si;
        x_re = '0;
        x_im = '0;
        case (cmd.kind)
            KIND_ADD: begin
                x_re = MAG_W'(cmd.a_re) + MAG_W'(cmd.b_re);
                x_im = MAG_W'(cmd.a_im) + MAG_W'(cmd.b_im);
            end
            KIND_SUB: begin
                x_re = MAG_W'(cmd.a_re) - MAG_W'(cmd.b_re);
                x_im = MAG_W'(cmd.a_im) - MAG_W'(cmd.b_im);
            end
            KIND_NEG: begin
                x_re = MAG_W'(0) - MAG_W'(cmd.a_re);
                x_im = MAG_W'(0) - MAG_W'(cmd.a_im);
            end
            default: begin
                x_re = '0;
                x_im = '0;
            end
        endcase
        r_re = sat_signed(x_re);
        r_im = sat_signed(x_im);
        s1_next.res.res_re   = r_re.val;
        s1_next.res.res_im   = r_im.val;
        s1_next.res.is_equal = (cmd.kind == KIND_CMP) && (cmd.a_re == cmd.b_re)
                               && (cmd.a_im == cmd.b_im);
        s1_next.res.status   = (r_re.sat || r_im.sat) ? ST_SAT : ST_OK;
    end

    // stage 2: cross sums and divisor
    always_comb begin
        logic [PW:0] rr, ii, ri, ir;
        rr = {s1_reg.p_rr[PW-1], s1_reg.p_rr};
        ii = {s1_reg.p_ii[PW-1], s1_reg.p_ii};
        ri = {s1_reg.p_ri[PW-1], s1_reg.p_ri};
        ir = {s1_reg.p_ir[PW-1], s1_reg.p_ir};
        s2_next.kind = s1_reg.kind;
        s2_next.res  = s1_reg.res;
        s2_next.den  = s1_reg.sq_r + s1_reg.sq_i;
        if (s1_reg.kind == KIND_DIV) begin
            s2_next.sum_re = rr + ii;
            s2_next.sum_im = ir - ri;
        end else begin
            s2_next.sum_re = rr - ii;
            s2_next.sum_im = ri + ir;
        end
    end

    // stage 3: product scaling, divider setup and overflow precheck
    always_comb begin
        logic [MAG_W-1:0] m_re, m_im;
        logic [NW-1:0]    n_re, n_im, t_re, t_im;
        sat_t             r_re, r_im;
        m_re = magnitude({s2_reg.sum_re[PW], s2_reg.sum_re});
        m_im = magnitude({s2_reg.sum_im[PW], s2_reg.sum_im});
        n_re = NW'(m_re[PW-1:0]) << FRAC_BITS;
        n_im = NW'(m_im[PW-1:0]) << FRAC_BITS;
        t_re = n_re >> (W + 1);
        t_im = n_im >> (W + 1);
        r_re = saturate(s2_reg.sum_re[PW], m_re >> FRAC_BITS, 1'b0);
        r_im = saturate(s2_reg.sum_im[PW], m_im >> FRAC_BITS, 1'b0);
        dst_next[0]        = '0;
        dst_next[0].res    = s2_reg.res;
        dst_next[0].den    = s2_reg.den;
        dst_next[0].neg_re = s2_reg.sum_re[PW];
        dst_next[0].neg_im = s2_reg.sum_im[PW];
        dst_next[0].num_re = m_re[PW-1:0];
        dst_next[0].num_im = m_im[PW-1:0];
        dst_next[0].rem_re = t_re[PW-1:0];
        dst_next[0].rem_im = t_im[PW-1:0];
        dst_next[0].ovf_re = t_re >= NW'(s2_reg.den);
        dst_next[0].ovf_im = t_im >= NW'(s2_reg.den);
        if (s2_reg.kind == KIND_MUL) begin
            dst_next[0].res.res_re = r_re.val;
            dst_next[0].res.res_im = r_im.val;
            dst_next[0].res.status = (r_re.sat || r_im.sat) ? ST_SAT : ST_OK;
        end else if (s2_reg.kind == KIND_DIV) begin
            if (s2_reg.den == '0) begin
                dst_next[0].res.res_re = '0;
                dst_next[0].res.res_im = '0;
                dst_next[0].res.status = ST_DIV0;
            end else begin
                dst_next[0].is_div = 1'b1;
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        localparam int BI = W - k;
        if (BI >= FRAC_BITS) begin : g_nb
            assign nb_re[k] = dst_reg[k].num_re[BI-FRAC_BITS];
            assign nb_im[k] = dst_reg[k].num_im[BI-FRAC_BITS];
        end else begin : g_zero
            assign nb_re[k] = 1'b0;
            assign nb_im[k] = 1'b0;
        end

        always_comb begin
            logic [PW:0] tr, ti, d;
            d  = {1'b0, dst_reg[k].den};
            tr = {dst_reg[k].rem_re, nb_re[k]};
            ti = {dst_reg[k].rem_im, nb_im[k]};
            dst_next[k+1] = dst_reg[k];
            if (tr >= d) begin
                dst_next[k+1].rem_re   = PW'(tr - d);
                dst_next[k+1].q_re[BI] = 1'b1;
            end else begin
                dst_next[k+1].rem_re = tr[PW-1:0];
            end
            if (ti >= d) begin
                dst_next[k+1].rem_im   = PW'(ti - d);
                dst_next[k+1].q_im[BI] = 1'b1;
            end else begin
                dst_next[k+1].rem_im = ti[PW-1:0];
            end
        end
    end

    always_comb begin
        sat_t r_re, r_im;
        r_re = saturate(dst_reg[NDIV].neg_re, MAG_W'(dst_reg[NDIV].q_re),
                        dst_reg[NDIV].ovf_re);
        r_im = saturate(dst_reg[NDIV].neg_im, MAG_W'(dst_reg[NDIV].q_im),
                        dst_reg[NDIV].ovf_im);
        out_next = dst_reg[NDIV].res;
        if (dst_reg[NDIV].is_div) begin
            out_next.res_re   = r_re.val;
            out_next.res_im   = r_im.val;
            out_next.is_equal = 1'b0;
            out_next.status   = (r_re.sat || r_im.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= NDIV; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg        <= cmd_valid;
            v2_reg        <= v1_reg;
            dv_reg[0]     <= v2_reg;
            for (int i = 0; i < NDIV; i++) begin
                dv_reg[i+1] <= dv_reg[i];
            end
            out_valid_reg <= dv_reg[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            out_reg <= out_next;
            for (int i = 0; i <= NDIV; i++) begin
                dst_reg[i] <= dst_next[i];
            end
        end
    end

    a_div0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_DIV0 |-> m_data.res_re == '0 && m_data.res_im == '0)
        else $error("divide by zero result not cleared");

    a_eq_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_equal |->
            m_data.status == ST_OK && m_data.res_re == '0 && m_data.res_im == '0)
        else $error("equality flag with nonzero result");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_SAT |->
            m_data.res_re == DATA_MAX || m_data.res_re == DATA_MIN ||
            m_data.res_im == DATA_MAX || m_data.res_im == DATA_MIN)
        else $error("saturation flagged without a clamped part");

    a_no_stall_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> m_valid)
        else $error("output dropped while stalled");

endmodule
`default_nettype wire

@@ test/tb_complex_arithmetic_unit.sv @@
`default_nettype none
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int EW = 2 * W + 4;
    localparam int N_RANDOM = 1830;

    typedef logic signed [EW-1:0] wide_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    req_t  s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    rsp_t  m_data;

    complex_arithmetic_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    rsp_t pending_results[$];
    int   n_errors = 0;
    int   n_results = 0;
    int   n_items = 0;
    bit   calm = 1'b0;

    // clamp an exact signed value into the data range
    function automatic data_t clamp_part(input wide_t v, inout logic [1:0] st);
        if (v > wide_t'(signed'(DATA_MAX))) begin
            st = ST_SAT;
            return DATA_MAX;
        end
        if (v < wide_t'(signed'(DATA_MIN))) begin
            st = ST_SAT;
            return DATA_MIN;
        end
        return data_t'(v);
    endfunction

    // truncating scaled divide of a signed numerator by a positive denominator
    function automatic wide_t scaled_quot(input wide_t num, input wide_t den);
        logic [EW+FRAC_BITS-1:0] m, q;
        logic neg;
        wide_t lim;
        neg = num < 0;
        m = neg ? -num : num;
        q = (m << FRAC_BITS) / (EW + FRAC_BITS)'(den);
        lim = wide_t'(1) << W;
        // anything beyond the data range only needs to saturate
        if (q > (EW + FRAC_BITS)'(lim)) q = (EW + FRAC_BITS)'(lim);
        return neg ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic rsp_t complex_result(input req_t r);
        rsp_t  o;
        wide_t ar, ai, br, bi, xr, xi, den;
        logic [1:0] st;
        o = '0;
        st = ST_OK;
        ar = wide_t'(r.a_re);
        ai = wide_t'(r.a_im);
        br = wide_t'(r.b_re);
        bi = wide_t'(r.b_im);
        case (r.req_type)
            REQ_ADD: begin
                o.res_re = clamp_part(ar + br, st);
                o.res_im = clamp_part(ai + bi, st);
            end
            REQ_SUB: begin
                o.res_re = clamp_part(ar - br, st);
                o.res_im = clamp_part(ai - bi, st);
            end
            REQ_MUL: begin
                xr = ar * br - ai * bi;
                xi = ar * bi + ai * br;
                // truncate toward zero
                xr = xr < 0 ? -((-xr) >>> FRAC_BITS) : xr >>> FRAC_BITS;
                xi = xi < 0 ? -((-xi) >>> FRAC_BITS) : xi >>> FRAC_BITS;
                o.res_re = clamp_part(xr, st);
                o.res_im = clamp_part(xi, st);
            end
            REQ_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    st = ST_DIV0;
                end else begin
                    o.res_re = clamp_part(scaled_quot(ar * br + ai * bi, den), st);
                    o.res_im = clamp_part(scaled_quot(ai * br - ar * bi, den), st);
                end
            end
            REQ_NEG: begin
                o.res_re = clamp_part(-ar, st);
                o.res_im = clamp_part(-ai, st);
            end
            REQ_CMP: o.is_equal = (r.a_re == r.b_re) && (r.a_im == r.b_im);
            default: ;
        endcase
        o.status = st;
        return o;
    endfunction

    // called at a falling edge; leaves valid high so the next item can follow at once
    task automatic send_item(input req_t r);
        while (!calm && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(complex_result(r));
        n_items++;
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_ready <= calm || ($urandom_range(0, 99) >= 16);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item %p", m_data);
                n_errors++;
            end else begin
                rsp_t e;
                e = pending_results.pop_front();
                n_results++;
                if (m_data.res_re !== e.res_re) begin
                    $error("res_re: expected %0d, actual %0d", e.res_re, m_data.res_re);
                    n_errors++;
                end
                if (m_data.res_im !== e.res_im) begin
                    $error("res_im: expected %0d, actual %0d", e.res_im, m_data.res_im);
                    n_errors++;
                end
                if (m_data.is_equal !== e.is_equal) begin
                    $error("is_equal: expected %0b, actual %0b", e.is_equal, m_data.is_equal);
                    n_errors++;
                end
                if (m_data.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_data.status);
                    n_errors++;
                end
            end
        end
    end

    function automatic data_t pick_part();
        case ($urandom_range(0, 9))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2: return data_t'($urandom_range(0, 4)) - 2;
            3, 4: return data_t'(signed'($urandom_range(0, 32'h3ffff)) - 32'h20000);
            5, 6: return data_t'(signed'($urandom_range(0, 32'h3fffff)) - 32'h200000);
            default: return data_t'($urandom);
        endcase
    endfunction

    typedef struct {
        req_t req;
        bit   known;
        rsp_t want;
    } step_t;

    step_t directed[$];

    task automatic add_row(input logic [2:0] op, input data_t ar, input data_t ai,
                           input data_t br, input data_t bi, input bit known,
                           input rsp_t want);
        step_t s;
        s.req = '{op, ar, ai, br, bi};
        s.known = known;
        s.want = want;
        directed.push_back(s);
    endtask

    initial begin
        #200000;
        $display("[complex_arithmetic_unit] ERROR");
        $finish;
    end

    initial begin
        req_t r;
        int   idle;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_row(REQ_ADD, 1, 2, 3, 4, 1, '{4, 6, 0, ST_OK});
        add_row(REQ_ADD, DATA_MAX, DATA_MIN, 1, -1, 1, '{DATA_MAX, DATA_MIN, 0, ST_SAT});
        add_row(REQ_SUB, DATA_MIN, DATA_MAX, 1, -1, 1, '{DATA_MIN, DATA_MAX, 0, ST_SAT});
        add_row(REQ_SUB, 10, -10, 3, 3, 1, '{7, -13, 0, ST_OK});
        add_row(REQ_MUL, 32'h10000, 0, 32'h20000, 32'h30000, 1,
                '{32'h20000, 32'h30000, 0, ST_OK});
        add_row(REQ_MUL, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN, 1,
                '{DATA_MAX, -32767, 0, ST_SAT});
        add_row(REQ_MUL, -1, 0, 1, 0, 1, '{0, 0, 0, ST_OK});
        add_row(REQ_DIV, 5, 7, 0, 0, 1, '{0, 0, 0, ST_DIV0});
        add_row(REQ_DIV, 32'h30000, 32'h10000, 32'h10000, 0, 0, '0);
        add_row(REQ_DIV, DATA_MAX, DATA_MIN, 1, 0, 1, '{DATA_MAX, DATA_MIN, 0, ST_SAT});
        add_row(REQ_DIV, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX, 0, '0);
        add_row(REQ_DIV, -7, 3, 32'h50000, -32'h20000, 0, '0);
        add_row(REQ_NEG, DATA_MIN, DATA_MAX, 0, 0, 1, '{DATA_MAX, DATA_MIN + 1, 0, ST_SAT});
        add_row(REQ_NEG, 0, -5, 9, 9, 1, '{0, 5, 0, ST_OK});
        add_row(REQ_CMP, 42, -3, 42, -3, 1, '{0, 0, 1, ST_OK});
        add_row(REQ_CMP, 42, -3, 42, -4, 1, '{0, 0, 0, ST_OK});
        add_row(REQ_CMP, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX, 1, '{0, 0, 1, ST_OK});
        add_row(3'd6, 1, 2, 3, 4, 1, '0);
        add_row(3'd7, DATA_MAX, DATA_MIN, -1, -1, 1, '0);

        foreach (directed[i]) begin
            if (directed[i].known && complex_result(directed[i].req) !== directed[i].want) begin
                $error("predictor row %0d: expected %p, actual %p", i,
                       directed[i].want, complex_result(directed[i].req));
                n_errors++;
            end
            send_item(directed[i].req);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            // a long run with no idling on either side
            calm = (k >= 600 && k < 900);
            r.req_type = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5));
            r.a_re = pick_part();
            r.a_im = pick_part();
            r.b_re = pick_part();
            r.b_im = pick_part();
            if (r.req_type == REQ_CMP && $urandom_range(0, 1)) begin
                r.b_re = r.a_re;
                if ($urandom_range(0, 2) != 0) r.b_im = r.a_im;
            end
            if (r.req_type == REQ_DIV && $urandom_range(0, 15) == 0) begin
                r.b_re = 0;
                r.b_im = 0;
            end
            send_item(r);
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        idle = 0;
        while (pending_results.size() != 0 && idle < 20000) begin
            @(posedge aclk);
            idle++;
        end
        repeat (2 * W + 20) @(posedge aclk);

        $display("sent %0d items over all request types, %0d results checked",
                 n_items, n_results);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("[complex_arithmetic_unit] OK");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("[complex_arithmetic_unit] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_fifo.sv
sv/cau_back.sv
sv/complex_arithmetic_unit.sv
test/tb_complex_arithmetic_unit.sv
